// ===== src/iuthp_pkg.sv =====
// shared types and constants of the ipv4/udp/tcp header parser
`timescale 1ns / 1ps
`default_nettype none
package iuthp_pkg;

	// byte position width inside a frame
	localparam int POS_W = 11;
	localparam int CNT_W = 32;

	// frame byte positions
	localparam logic [POS_W-1:0] ETYPE_HI_POS  = 11'd12;
	localparam logic [POS_W-1:0] ETYPE_LO_POS  = 11'd13;
	localparam logic [POS_W-1:0] ETH_HDR_BYTES = 11'd14;
	localparam logic [POS_W-1:0] IP_PROTO_POS  = 11'd23;
	localparam logic [POS_W-1:0] SRC_ADDR_POS  = 11'd26;
	localparam logic [POS_W-1:0] DST_ADDR_POS  = 11'd30;
	localparam logic [POS_W-1:0] ADDR_BYTES    = 11'd4;

	// positions relative to the start of the layer 4 header
	localparam logic [POS_W-1:0] PORT_BYTES    = 11'd2;
	localparam logic [POS_W-1:0] TCP_OFF_POS   = 11'd12;
	localparam logic [POS_W-1:0] UDP_HDR_BYTES = 11'd8;

	// header values
	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  PROTO_UDP      = 8'd17;
	localparam logic [7:0]  PROTO_TCP      = 8'd6;

	// frame class codes
	localparam logic [1:0] CLASS_NONE  = 2'd0;
	localparam logic [1:0] CLASS_IPV4  = 2'd1;
	localparam logic [1:0] CLASS_UDP   = 2'd2;
	localparam logic [1:0] CLASS_TCP   = 2'd3;

	// summary queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = 2;

	// what the front hands over for one finished frame
	typedef struct packed {
		logic             ipv4;
		logic [7:0]       protocol;
		logic [3:0]       header_words;
		logic [3:0]       tcp_words;
		logic [31:0]      src_addr;
		logic [31:0]      dst_addr;
		logic [15:0]      src_port;
		logic [15:0]      dst_port;
		logic [POS_W-1:0] length;
	} frame_rec_t;

endpackage
`default_nettype wire

// ===== src/iuthp_front.sv =====
// front part: walks frame bytes, captures header fields, emits a frame summary
`timescale 1ns / 1ps
`default_nettype none
module iuthp_front #(
	parameter int MAX_FRAME_BYTES = 2048
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  accept,
	input  wire logic [7:0]            frame_byte,
	input  wire logic                  last_byte,
	output logic                       rec_push,
	output iuthp_pkg::frame_rec_t      rec
);
	import iuthp_pkg::*;

	localparam int CapInt = (MAX_FRAME_BYTES < 2047) ? MAX_FRAME_BYTES : 2047;
	localparam logic [POS_W-1:0] POS_CAP = POS_W'(CapInt);

	logic [POS_W-1:0] pos_q;
	logic [15:0]      etype_q, etype_n;
	logic [3:0]       hw_q, hw_n;
	logic [7:0]       proto_q, proto_n;
	logic [31:0]      sa_q, sa_n, da_q, da_n;
	logic [15:0]      sp_q, sp_n, dp_q, dp_n;
	logic [3:0]       tcpw_q, tcpw_n;
	logic             in_range;
	logic [POS_W-1:0] l4;
	logic [POS_W-1:0] len_n;

	// header length is taken from the byte itself when it arrives
	assign in_range = (pos_q < POS_CAP);
	assign hw_n     = (in_range && pos_q == ETH_HDR_BYTES) ? frame_byte[3:0] : hw_q;
	assign l4       = ETH_HDR_BYTES + POS_W'({hw_n, 2'b00});
	assign len_n    = in_range ? pos_q + POS_W'(1) : POS_CAP;

	// field capture for the current byte
	always_comb begin
		etype_n = etype_q;
		proto_n = proto_q;
		sa_n    = sa_q;
		da_n    = da_q;
		sp_n    = sp_q;
		dp_n    = dp_q;
		tcpw_n  = tcpw_q;
		if (in_range) begin
			if (pos_q == ETYPE_HI_POS) etype_n = {frame_byte, etype_q[7:0]};
			if (pos_q == ETYPE_LO_POS) etype_n = {etype_q[15:8], frame_byte};
			if (pos_q == IP_PROTO_POS) proto_n = frame_byte;
			if (pos_q >= SRC_ADDR_POS && pos_q < SRC_ADDR_POS + ADDR_BYTES)
				sa_n = {sa_q[23:0], frame_byte};
			if (pos_q >= DST_ADDR_POS && pos_q < DST_ADDR_POS + ADDR_BYTES)
				da_n = {da_q[23:0], frame_byte};
			if (pos_q >= l4 && pos_q < l4 + PORT_BYTES)
				sp_n = {sp_q[7:0], frame_byte};
			if (pos_q >= l4 + PORT_BYTES && pos_q < l4 + PORT_BYTES + PORT_BYTES)
				dp_n = {dp_q[7:0], frame_byte};
			if (pos_q == l4 + TCP_OFF_POS) tcpw_n = frame_byte[7:4];
		end
	end

	// summary of the frame as it stands after this byte
	always_comb begin
		rec.ipv4         = (len_n >= ETH_HDR_BYTES) && (etype_n == ETHERTYPE_IPV4);
		rec.protocol     = proto_n;
		rec.header_words = hw_n;
		rec.tcp_words    = tcpw_n;
		rec.src_addr     = sa_n;
		rec.dst_addr     = da_n;
		rec.src_port     = sp_n;
		rec.dst_port     = dp_n;
		rec.length       = len_n;
	end

	assign rec_push = accept & last_byte;

	// capture registers, cleared after every final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			etype_q <= '0;
			hw_q    <= '0;
			proto_q <= '0;
			sa_q    <= '0;
			da_q    <= '0;
			sp_q    <= '0;
			dp_q    <= '0;
			tcpw_q  <= '0;
		end else if (accept) begin
			if (last_byte) begin
				pos_q   <= '0;
				etype_q <= '0;
				hw_q    <= '0;
				proto_q <= '0;
				sa_q    <= '0;
				da_q    <= '0;
				sp_q    <= '0;
				dp_q    <= '0;
				tcpw_q  <= '0;
			end else begin
				pos_q   <= len_n;
				etype_q <= etype_n;
				hw_q    <= hw_n;
				proto_q <= proto_n;
				sa_q    <= sa_n;
				da_q    <= da_n;
				sp_q    <= sp_n;
				dp_q    <= dp_n;
				tcpw_q  <= tcpw_n;
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/iuthp_queue.sv =====
// short queue of frame summaries between front and back
`timescale 1ns / 1ps
`default_nettype none
module iuthp_queue (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  wr_en,
	input  wire iuthp_pkg::frame_rec_t wr_rec,
	output logic                       full,
	output logic                       rd_valid,
	input  wire logic                  rd_en,
	output iuthp_pkg::frame_rec_t      rd_rec
);
	import iuthp_pkg::*;

	frame_rec_t          entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;
	logic                do_wr, do_rd;

	assign full     = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_rec   = entry_q[rd_ptr_q];
	assign do_wr    = wr_en & ~full;
	assign do_rd    = rd_en & rd_valid;

	// entry storage
	always_ff @(posedge clk) begin
		if (do_wr) entry_q[wr_ptr_q] <= wr_rec;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			if (do_rd) rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			if (do_wr && !do_rd) count_q <= count_q + (QUEUE_AW+1)'(1);
			else if (do_rd && !do_wr) count_q <= count_q - (QUEUE_AW+1)'(1);
		end
	end

endmodule
`default_nettype wire

// ===== src/iuthp_back.sv =====
// back part: classifies a frame summary, keeps the counts, holds the result
`timescale 1ns / 1ps
`default_nettype none
module iuthp_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        rec_valid,
	input  wire iuthp_pkg::frame_rec_t       rec,
	output logic                             rec_take,
	output logic                             empty,
	input  wire logic                        pop,
	output logic [1:0]                       frame_class,
	output logic [31:0]                      source_address,
	output logic [31:0]                      dest_address,
	output logic [15:0]                      source_port,
	output logic [15:0]                      dest_port,
	output logic [iuthp_pkg::POS_W-1:0]      payload_offset,
	output logic [iuthp_pkg::POS_W-1:0]      payload_length,
	output logic [iuthp_pkg::CNT_W-1:0]      frames_seen,
	output logic [iuthp_pkg::CNT_W-1:0]      ipv4_seen,
	output logic [iuthp_pkg::CNT_W-1:0]      udp_seen,
	output logic [iuthp_pkg::CNT_W-1:0]      tcp_seen
);
	import iuthp_pkg::*;

	logic             out_valid_q;
	logic [1:0]       cls_q, cls_n;
	logic [31:0]      sa_q, sa_n, da_q, da_n;
	logic [15:0]      sp_q, sp_n, dp_q, dp_n;
	logic [POS_W-1:0] off_q, off_n, plen_q, plen_n;
	logic [CNT_W-1:0] frames_q, ipv4_q, udp_q, tcp_q;
	logic [POS_W-1:0] l4;

	// take a new request when the result register is free or being drained
	assign rec_take = rec_valid & (~out_valid_q | pop);
	assign l4       = ETH_HDR_BYTES + POS_W'({rec.header_words, 2'b00});

	// classification and payload placement
	always_comb begin
		cls_n  = CLASS_NONE;
		sa_n   = '0;
		da_n   = '0;
		sp_n   = '0;
		dp_n   = '0;
		off_n  = '0;
		plen_n = '0;
		if (rec.ipv4) begin
			cls_n = CLASS_IPV4;
			sa_n  = rec.src_addr;
			da_n  = rec.dst_addr;
			sp_n  = rec.src_port;
			dp_n  = rec.dst_port;
			if (rec.protocol == PROTO_UDP) begin
				cls_n = CLASS_UDP;
				off_n = l4 + UDP_HDR_BYTES;
			end else if (rec.protocol == PROTO_TCP) begin
				cls_n = CLASS_TCP;
				off_n = l4 + POS_W'({rec.tcp_words, 2'b00});
			end
			if (cls_n == CLASS_UDP || cls_n == CLASS_TCP)
				plen_n = (rec.length > off_n) ? rec.length - off_n : '0;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (rec_take) begin
			cls_q  <= cls_n;
			sa_q   <= sa_n;
			da_q   <= da_n;
			sp_q   <= sp_n;
			dp_q   <= dp_n;
			off_q  <= off_n;
			plen_q <= plen_n;
		end
	end

	// valid flag and running counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			frames_q    <= '0;
			ipv4_q      <= '0;
			udp_q       <= '0;
			tcp_q       <= '0;
		end else begin
			if (rec_take) out_valid_q <= 1'b1;
			else if (pop) out_valid_q <= 1'b0;
			if (rec_take) begin
				frames_q <= frames_q + CNT_W'(1);
				if (rec.ipv4) ipv4_q <= ipv4_q + CNT_W'(1);
				if (cls_n == CLASS_UDP) udp_q <= udp_q + CNT_W'(1);
				if (cls_n == CLASS_TCP) tcp_q <= tcp_q + CNT_W'(1);
			end
		end
	end

	// counts only move when a new result loads, so they match the shown result
	assign empty          = ~out_valid_q;
	assign frame_class    = cls_q;
	assign source_address = sa_q;
	assign dest_address   = da_q;
	assign source_port    = sp_q;
	assign dest_port      = dp_q;
	assign payload_offset = off_q;
	assign payload_length = plen_q;
	assign frames_seen    = frames_q;
	assign ipv4_seen      = ipv4_q;
	assign udp_seen       = udp_q;
	assign tcp_seen       = tcp_q;

endmodule
`default_nettype wire

// ===== src/ipv4_udp_tcp_header_parser.sv =====
// Ethernet/IPv4/UDP/TCP header parser top level.
// Takes one frame byte per clock cycle while full is low, with no gaps needed
// between frames; the front walks the bytes and captures header fields, and on
// the final byte of a frame writes a summary into a four-entry queue. The back
// takes one summary per cycle while its result register is free or being popped,
// classifies it, updates the running counts and loads the result register; a
// result shows (empty low) once the back has loaded its summary from the queue.
// full rises only when four frame summaries wait because results are not popped.
// Frames longer than the smaller of MAX_FRAME_BYTES and 2047 bytes are counted
// only up to that length.
`timescale 1ns / 1ps
`default_nettype none
module ipv4_udp_tcp_header_parser #(
	parameter int MAX_FRAME_BYTES = 2048
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        push,
	output logic                             full,
	input  wire logic [7:0]                  frame_byte,
	input  wire logic                        last_byte,
	output logic                             empty,
	input  wire logic                        pop,
	output logic [1:0]                       frame_class,
	output logic [31:0]                      source_address,
	output logic [31:0]                      dest_address,
	output logic [15:0]                      source_port,
	output logic [15:0]                      dest_port,
	output logic [iuthp_pkg::POS_W-1:0]      payload_offset,
	output logic [iuthp_pkg::POS_W-1:0]      payload_length,
	output logic [iuthp_pkg::CNT_W-1:0]      frames_seen,
	output logic [iuthp_pkg::CNT_W-1:0]      ipv4_seen,
	output logic [iuthp_pkg::CNT_W-1:0]      udp_seen,
	output logic [iuthp_pkg::CNT_W-1:0]      tcp_seen
);
	import iuthp_pkg::*;

	logic       accept;
	logic       rec_push;
	frame_rec_t front_rec;
	logic       q_valid;
	logic       q_take;
	frame_rec_t q_rec;

	// a byte request is taken while the summary queue has room
	assign accept = push & ~full;

	// byte walker
	iuthp_front #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.frame_byte(frame_byte),
		.last_byte (last_byte),
		.rec_push  (rec_push),
		.rec       (front_rec)
	);

	// summary queue
	iuthp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (rec_push),
		.wr_rec  (front_rec),
		.full    (full),
		.rd_valid(q_valid),
		.rd_en   (q_take),
		.rd_rec  (q_rec)
	);

	// classifier and result register
	iuthp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.rec_valid     (q_valid),
		.rec           (q_rec),
		.rec_take      (q_take),
		.empty         (empty),
		.pop           (pop),
		.frame_class   (frame_class),
		.source_address(source_address),
		.dest_address  (dest_address),
		.source_port   (source_port),
		.dest_port     (dest_port),
		.payload_offset(payload_offset),
		.payload_length(payload_length),
		.frames_seen   (frames_seen),
		.ipv4_seen     (ipv4_seen),
		.udp_seen      (udp_seen),
		.tcp_seen      (tcp_seen)
	);

endmodule
`default_nettype wire

// ===== src/iuthp_checker.sv =====
// port-level checks of the header parser and their binding
`timescale 1ns / 1ps
`default_nettype none
module iuthp_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        empty,
	input  wire logic        pop,
	input  wire logic [1:0]  frame_class,
	input  wire logic [31:0] source_address,
	input  wire logic [31:0] dest_address,
	input  wire logic [15:0] source_port,
	input  wire logic [15:0] dest_port,
	input  wire logic [10:0] payload_offset,
	input  wire logic [10:0] payload_length,
	input  wire logic [31:0] frames_seen
);
	import iuthp_pkg::*;

	// a waiting result holds until popped
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(frame_class) && $stable(frames_seen)
			&& $stable(source_address) && $stable(payload_length))
		else $error("waiting result changed before pop");

	// a non-ipv4 frame reports no header fields
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && frame_class == CLASS_NONE |-> source_address == '0
			&& dest_address == '0 && source_port == '0 && dest_port == '0
			&& payload_offset == '0 && payload_length == '0)
		else $error("non-ipv4 result carries header fields");

	// other ipv4 has no payload placement
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && frame_class == CLASS_IPV4 |-> payload_offset == '0
			&& payload_length == '0)
		else $error("other ipv4 result carries payload placement");

	// udp and tcp payload starts past the ethernet header
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (frame_class == CLASS_UDP || frame_class == CLASS_TCP)
			|-> payload_offset >= ETH_HDR_BYTES)
		else $error("payload offset inside ethernet header");

endmodule

bind ipv4_udp_tcp_header_parser iuthp_checker u_iuthp_checker (.*);
`default_nettype wire

// ===== test/ipv4_udp_tcp_header_parser_tb.sv =====
// self-checking testbench for the ipv4/udp/tcp header parser
`timescale 1ns / 1ps
module ipv4_udp_tcp_header_parser_tb;
	import iuthp_pkg::*;

	localparam int MAX_FRAME_BYTES = 2048;
	localparam int unsigned BYTE_CAP = (MAX_FRAME_BYTES < 2047) ? MAX_FRAME_BYTES : 2047;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 16;
	localparam int PHASE_BYTES = 150;
	localparam int PHASE_FRAMES = 3;

	// idle mixes per random phase: none, sender idle, receiver stall, both
	localparam int SEND_IDLE [4] = '{0, 82, 0, 37};
	localparam int RECV_STALL [4] = '{0, 0, 82, 37};

	// frame body fill patterns
	localparam logic [1:0] FILL_RANDOM = 2'd0;
	localparam logic [1:0] FILL_ZERO   = 2'd1;
	localparam logic [1:0] FILL_ONES   = 2'd2;

	// one frame to send; when known is set, class, offset and length are typed in
	typedef struct packed {
		logic [11:0] n_bytes;
		logic [1:0]  fill;
		logic [15:0] etype;
		logic [7:0]  ver_ihl;
		logic [7:0]  proto;
		logic [7:0]  tcp_off_byte;
		logic        known;
		logic        zero_fields;
		logic [1:0]  cls;
		logic [10:0] off;
		logic [10:0] plen;
	} frame_spec_t;

	// one frame summary as it leaves the parser
	typedef struct packed {
		logic [1:0]  cls;
		logic [31:0] saddr;
		logic [31:0] daddr;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [10:0] off;
		logic [10:0] plen;
		logic [31:0] frames;
		logic [31:0] ipv4;
		logic [31:0] udp;
		logic [31:0] tcp;
	} summary_t;

	// directed frames: size, fill, ethertype, version/ihl, protocol, tcp offset byte,
	// known, zero addresses and ports, class, payload offset, payload length
	localparam int DIRECTED_COUNT = 19;
	localparam frame_spec_t DIRECTED_FRAMES [DIRECTED_COUNT] = '{
		'{1, FILL_RANDOM, 'h0800, 'h45, PROTO_UDP, 'h50, 1, 1, CLASS_NONE, 0, 0},
		'{13, FILL_ONES, 'h0800, 'h45, PROTO_UDP, 'h50, 1, 1, CLASS_NONE, 0, 0},
		'{14, FILL_ONES, 'h0800, 'h45, PROTO_UDP, 'h50, 1, 1, CLASS_IPV4, 0, 0},
		'{60, FILL_ONES, 'h86DD, 'h45, PROTO_UDP, 'h50, 1, 1, CLASS_NONE, 0, 0},
		'{60, FILL_ZERO, 'h0800, 'h45, 'h01, 'h50, 1, 1, CLASS_IPV4, 0, 0},
		'{24, FILL_ONES, 'h0800, 'h45, PROTO_UDP, 'h50, 1, 1, CLASS_UDP, 42, 0},
		'{42, FILL_RANDOM, 'h0800, 'h45, PROTO_UDP, 'h50, 1, 0, CLASS_UDP, 42, 0},
		'{100, FILL_ONES, 'h0800, 'h45, PROTO_UDP, 'h50, 1, 0, CLASS_UDP, 42, 58},
		'{54, FILL_RANDOM, 'h0800, 'h45, PROTO_TCP, 'h50, 1, 0, CLASS_TCP, 54, 0},
		'{30, FILL_RANDOM, 'h0800, 'h45, PROTO_TCP, 'h50, 1, 0, CLASS_TCP, 34, 0},
		'{200, FILL_RANDOM, 'h0800, 'h4F, PROTO_TCP, 'hF0, 1, 0, CLASS_TCP, 134, 66},
		'{80, FILL_RANDOM, 'h0800, 'h45, PROTO_TCP, 'h0F, 1, 0, CLASS_TCP, 34, 46},
		'{50, FILL_RANDOM, 'h0800, 'h40, PROTO_UDP, 'h50, 0, 0, CLASS_NONE, 0, 0},
		'{60, FILL_RANDOM, 'h0800, 'h43, PROTO_TCP, 'h50, 0, 0, CLASS_NONE, 0, 0},
		'{2048, FILL_RANDOM, 'h0800, 'h45, PROTO_UDP, 'h50, 1, 0, CLASS_UDP, 42, 2005},
		'{120, FILL_ONES, 'h0800, 'hFF, PROTO_UDP, 'hFF, 0, 0, CLASS_NONE, 0, 0},
		'{64, FILL_ZERO, 'h0008, 'h45, PROTO_UDP, 'h50, 1, 1, CLASS_NONE, 0, 0},
		'{64, FILL_ONES, 'h0800, 'h45, 'hFF, 'hFF, 0, 0, CLASS_NONE, 0, 0},
		'{64, FILL_ZERO, 'h0800, 'h45, PROTO_UDP, 'h00, 1, 1, CLASS_UDP, 42, 22}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic [7:0] frame_byte = 8'h00;
	logic last_byte = 1'b0;
	logic pop = 1'b0;
	logic full;
	logic empty;
	logic [1:0] frame_class;
	logic [31:0] source_address;
	logic [31:0] dest_address;
	logic [15:0] source_port;
	logic [15:0] dest_port;
	logic [POS_W-1:0] payload_offset;
	logic [POS_W-1:0] payload_length;
	logic [CNT_W-1:0] frames_seen;
	logic [CNT_W-1:0] ipv4_seen;
	logic [CNT_W-1:0] udp_seen;
	logic [CNT_W-1:0] tcp_seen;

	// parser state mirrored by the predictor
	int unsigned pos_q;
	logic [15:0] etype_q;
	logic [3:0] hdr_words_q;
	logic [7:0] proto_q;
	logic [31:0] saddr_q;
	logic [31:0] daddr_q;
	logic [15:0] sport_q;
	logic [15:0] dport_q;
	logic [3:0] tcp_words_q;
	logic [31:0] frame_cnt;
	logic [31:0] n_ipv4;
	logic [31:0] n_udp;
	logic [31:0] n_tcp;

	summary_t expected_summaries [$];
	frame_spec_t pending_specs [$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int errors = 0;
	int cycle_count = 0;
	int frames_sent = 0;
	int bytes_sent = 0;
	int results_checked = 0;
	int class_hist [4] = '{0, 0, 0, 0};

	ipv4_udp_tcp_header_parser #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.frame_byte(frame_byte),
		.last_byte(last_byte),
		.empty(empty),
		.pop(pop),
		.frame_class(frame_class),
		.source_address(source_address),
		.dest_address(dest_address),
		.source_port(source_port),
		.dest_port(dest_port),
		.payload_offset(payload_offset),
		.payload_length(payload_length),
		.frames_seen(frames_seen),
		.ipv4_seen(ipv4_seen),
		.udp_seen(udp_seen),
		.tcp_seen(tcp_seen)
	);

	// 100 MHz clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// clear the per-frame capture
	task automatic clear_capture();
		pos_q = 0;
		etype_q = '0;
		hdr_words_q = '0;
		proto_q = '0;
		saddr_q = '0;
		daddr_q = '0;
		sport_q = '0;
		dport_q = '0;
		tcp_words_q = '0;
	endtask

	// advance the predictor by one accepted byte, queue a summary on the last one
	task automatic parse_byte(input logic [7:0] b, input logic is_last);
		int unsigned p;
		int unsigned l4;
		int unsigned len;
		int unsigned off;
		summary_t s;
		frame_spec_t spec;
		p = pos_q;
		if (p < BYTE_CAP) begin
			if (p == ETYPE_HI_POS) etype_q[15:8] = b;
			if (p == ETYPE_LO_POS) etype_q[7:0] = b;
			if (p == ETH_HDR_BYTES) hdr_words_q = b[3:0];
			if (p == IP_PROTO_POS) proto_q = b;
			if (p >= SRC_ADDR_POS && p < SRC_ADDR_POS + ADDR_BYTES)
				saddr_q = {saddr_q[23:0], b};
			if (p >= DST_ADDR_POS && p < DST_ADDR_POS + ADDR_BYTES)
				daddr_q = {daddr_q[23:0], b};
			// port window follows the header length as seen so far
			l4 = ETH_HDR_BYTES + hdr_words_q * 4;
			if (p >= l4 && p < l4 + PORT_BYTES) sport_q = {sport_q[7:0], b};
			if (p >= l4 + PORT_BYTES && p < l4 + 2 * PORT_BYTES)
				dport_q = {dport_q[7:0], b};
			if (p == l4 + TCP_OFF_POS) tcp_words_q = b[7:4];
			len = p + 1;
		end else begin
			len = BYTE_CAP;
		end
		if (!is_last) begin
			pos_q = len;
			return;
		end

		// end of frame: classify and count
		s = '0;
		off = 0;
		frame_cnt++;
		if (len >= ETH_HDR_BYTES && etype_q == ETHERTYPE_IPV4) begin
			l4 = ETH_HDR_BYTES + hdr_words_q * 4;
			n_ipv4++;
			s.cls = CLASS_IPV4;
			s.saddr = saddr_q;
			s.daddr = daddr_q;
			s.sport = sport_q;
			s.dport = dport_q;
			if (proto_q == PROTO_UDP) begin
				n_udp++;
				s.cls = CLASS_UDP;
				off = l4 + UDP_HDR_BYTES;
			end else if (proto_q == PROTO_TCP) begin
				n_tcp++;
				s.cls = CLASS_TCP;
				off = l4 + tcp_words_q * 4;
			end
			if (s.cls == CLASS_UDP || s.cls == CLASS_TCP) begin
				s.off = off[10:0];
				s.plen = (len > off) ? 11'(len - off) : 11'd0;
			end
		end
		s.frames = frame_cnt;
		s.ipv4 = n_ipv4;
		s.udp = n_udp;
		s.tcp = n_tcp;

		// directed frames carry their class, offset and length typed in
		spec = pending_specs.pop_front();
		if (spec.known) begin
			s.cls = spec.cls;
			s.off = spec.off;
			s.plen = spec.plen;
			if (spec.zero_fields) begin
				s.saddr = '0;
				s.daddr = '0;
				s.sport = '0;
				s.dport = '0;
			end
		end
		expected_summaries = {expected_summaries, s};
		clear_capture();
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
			errors++;
		end
	endtask

	// compare one popped summary against the oldest expectation
	task automatic check_result();
		summary_t got;
		summary_t want;
		got = '{frame_class, source_address, dest_address, source_port, dest_port,
			payload_offset, payload_length, frames_seen, ipv4_seen, udp_seen, tcp_seen};
		if (expected_summaries.size() == 0) begin
			$display("%0t: unexpected result, expected none, got class %0d", $time,
				got.cls);
			errors++;
			return;
		end
		want = expected_summaries.pop_front();
		check_field("frame_class", want.cls, got.cls);
		check_field("source_address", want.saddr, got.saddr);
		check_field("dest_address", want.daddr, got.daddr);
		check_field("source_port", want.sport, got.sport);
		check_field("dest_port", want.dport, got.dport);
		check_field("payload_offset", want.off, got.off);
		check_field("payload_length", want.plen, got.plen);
		check_field("frames_seen", want.frames, got.frames);
		check_field("ipv4_seen", want.ipv4, got.ipv4);
		check_field("udp_seen", want.udp, got.udp);
		check_field("tcp_seen", want.tcp, got.tcp);
		results_checked++;
		class_hist[want.cls]++;
	endtask

	// watch both handshakes at each edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) check_result();
			if (push && !full) parse_byte(frame_byte, last_byte);
		end
	end

	// receiver: random stalls on pop
	always @(posedge clk) begin
		pop <= ($urandom_range(99) >= recv_stall_pct);
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time,
				expected_summaries.size());
			$display("ipv4_udp_tcp_header_parser test failed");
			$finish;
		end
	end

	// one frame byte per push request, with random idle cycles ahead of it
	task automatic send_byte(input logic [7:0] b, input logic is_last);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		frame_byte <= b;
		last_byte <= is_last;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	// build the frame bytes from a spec and send them
	task automatic send_frame(input frame_spec_t spec);
		logic [7:0] frame_bytes [];
		int unsigned l4;
		frame_bytes = new[spec.n_bytes];
		for (int i = 0; i < spec.n_bytes; i++) begin
			case (spec.fill)
				FILL_ZERO: frame_bytes[i] = 8'h00;
				FILL_ONES: frame_bytes[i] = 8'hFF;
				default: frame_bytes[i] = 8'($urandom_range(255));
			endcase
		end
		l4 = ETH_HDR_BYTES + spec.ver_ihl[3:0] * 4;
		if (spec.n_bytes > ETYPE_HI_POS) frame_bytes[ETYPE_HI_POS] = spec.etype[15:8];
		if (spec.n_bytes > ETYPE_LO_POS) frame_bytes[ETYPE_LO_POS] = spec.etype[7:0];
		if (spec.n_bytes > ETH_HDR_BYTES) frame_bytes[ETH_HDR_BYTES] = spec.ver_ihl;
		if (spec.n_bytes > IP_PROTO_POS) frame_bytes[IP_PROTO_POS] = spec.proto;
		if (spec.n_bytes > l4 + TCP_OFF_POS) frame_bytes[l4 + TCP_OFF_POS] = spec.tcp_off_byte;
		pending_specs = {pending_specs, spec};
		for (int i = 0; i < spec.n_bytes; i++)
			send_byte(frame_bytes[i], i == spec.n_bytes - 1);
		frames_sent++;
		bytes_sent += spec.n_bytes;
	endtask

	// mostly well-formed udp/tcp frames, some noise and truncated ones
	function automatic frame_spec_t random_frame_spec();
		frame_spec_t s;
		int unsigned kind;
		int unsigned pick;
		int unsigned l4;
		int unsigned l4_hdr;
		s = '0;
		s.fill = FILL_RANDOM;
		s.etype = ETHERTYPE_IPV4;
		s.ver_ihl = 8'h45;
		s.tcp_off_byte = {4'd5, 4'($urandom_range(15))};
		pick = $urandom_range(99);
		s.proto = (pick < 45) ? PROTO_UDP : (pick < 85) ? PROTO_TCP : 8'($urandom_range(255));
		kind = $urandom_range(99);
		if (kind < 10) begin
			// not ipv4, or too short to tell
			s.etype = 16'($urandom_range(16'hFFFF));
			s.n_bytes = 12'($urandom_range(40, 1));
		end else if (kind < 18) begin
			// ipv4 cut off inside the headers
			s.n_bytes = 12'($urandom_range(40, 14));
		end else begin
			if ($urandom_range(4) == 0) s.ver_ihl = 8'($urandom_range(255));
			if ($urandom_range(4) == 0) s.tcp_off_byte = 8'($urandom_range(255));
			l4 = ETH_HDR_BYTES + s.ver_ihl[3:0] * 4;
			l4_hdr = (s.proto == PROTO_TCP) ? s.tcp_off_byte[7:4] * 4 : UDP_HDR_BYTES;
			s.n_bytes = 12'(l4 + l4_hdr +
				(($urandom_range(19) == 0) ? $urandom_range(600) : $urandom_range(40)));
		end
		return s;
	endfunction

	// stimulus and end of run
	initial begin
		int phase_bytes;
		int phase_frames;
		clear_capture();
		frame_cnt = '0;
		n_ipv4 = '0;
		n_udp = '0;
		n_tcp = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed frames with no idling
		for (int i = 0; i < DIRECTED_COUNT; i++) send_frame(DIRECTED_FRAMES[i]);

		// random frames under each idle mix
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = SEND_IDLE[ph];
			recv_stall_pct = RECV_STALL[ph];
			phase_bytes = bytes_sent;
			phase_frames = frames_sent;
			while (bytes_sent - phase_bytes < PHASE_BYTES ||
					frames_sent - phase_frames < PHASE_FRAMES)
				send_frame(random_frame_spec());
		end
		push <= 1'b0;

		// drain outstanding results, then watch for strays
		while (expected_summaries.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d frames (%0d bytes) under four idle mixes", frames_sent, bytes_sent);
		$display("checked %0d summaries: %0d not ipv4, %0d other ipv4, %0d udp, %0d tcp",
			results_checked, class_hist[CLASS_NONE], class_hist[CLASS_IPV4],
			class_hist[CLASS_UDP], class_hist[CLASS_TCP]);
		if (errors == 0) begin
			$display("ipv4_udp_tcp_header_parser test passed");
		end else begin
			$display("ipv4_udp_tcp_header_parser test failed");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
src/iuthp_pkg.sv
src/iuthp_front.sv
src/iuthp_queue.sv
src/iuthp_back.sv
src/ipv4_udp_tcp_header_parser.sv
src/iuthp_checker.sv
test/ipv4_udp_tcp_header_parser_tb.sv
